FILE: design/thds_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thds_pkg
// shared constants and types of the timestamped history dedup store
// ----------------------------------------------------------------------------
package thds_pkg;
  localparam int Depth = 64;
  localparam int CntW  = $clog2(Depth + 1);

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_RSVD  = 2'd3;

  localparam logic [2:0] ST_CLEARED  = 3'd0;
  localparam logic [2:0] ST_APPENDED = 3'd1;
  localparam logic [2:0] ST_REPLACED = 3'd2;
  localparam logic [2:0] ST_DUP      = 3'd3;
  localparam logic [2:0] ST_INVALID  = 3'd4;
  localparam logic [2:0] ST_TOO_OLD  = 3'd5;
  localparam logic [2:0] ST_READ     = 3'd6;

  typedef struct packed {
    logic [23:0] value;
    logic [31:0] tstamp;
  } entry_t;

  // ring control: shift one place, and optionally load a new entry at the tail
  typedef struct packed {
    logic   shift;
    logic   load;
    entry_t data;
  } ring_ctl_t;
endpackage
`default_nettype wire

FILE: design/thds_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thds_cell
// one slot of the circulating entry ring
// ----------------------------------------------------------------------------
module thds_cell (
  input  wire                   clk,
  input  wire                   shift,
  input  wire  thds_pkg::entry_t din,
  output thds_pkg::entry_t       dout
);
  import thds_pkg::*;
  always_ff @(posedge clk) begin
    if (shift) begin
      dout <= din;
    end
  end
endmodule
`default_nettype wire

FILE: design/thds_ring.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thds_ring
// chain of cells; the tail takes a loaded entry or is fed back from cell 0, the head
// ----------------------------------------------------------------------------
module thds_ring (
  input  wire                    clk,
  input  wire  thds_pkg::ring_ctl_t ctl,
  output thds_pkg::entry_t        head
);
  import thds_pkg::*;
  entry_t q [Depth];
  entry_t d [Depth];

  genvar g;
  generate
    for (g = 0; g < Depth; g++) begin : g_cell
      if (g == Depth - 1) begin : g_tail
        assign d[g] = ctl.load ? ctl.data : q[0];
      end else begin : g_mid
        assign d[g] = q[g+1];
      end
      thds_cell u_cell (.clk(clk), .shift(ctl.shift), .din(d[g]), .dout(q[g]));
    end
  endgenerate

  assign head = q[0];
endmodule
`default_nettype wire

FILE: design/timestamped_history_dedup_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// timestamped_history_dedup_store
// bounded store of timestamped readings with duplicate suppression
// ----------------------------------------------------------------------------
// Entries live in a ring of Depth cells that rotates one place per cycle
// while busy; slot 0 always sits at the head between commands. A clear,
// an invalid add, an empty read and the unused code are handled at the
// accepting edge and busy never rises; the result beat of the first three
// shows in the next cycle, and the unused code gives no result beat. A
// valid add rotates the ring once fully to look for a duplicate timestamp
// and the oldest entry; a duplicate or a too-old sample ends there.
// Otherwise a second full turn writes the sample in its slot; the result
// beat shows in the first cycle after busy falls. A read rotates once and
// emits one beat per cycle, each taken from the head in the read state
// and registered, for the first entries up to the limit. The receiver
// cannot stall: every result beat is shown for one cycle with strobe
// high, and busy stays high until the command's work is done.
module timestamped_history_dedup_store (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         start,
  output logic                        busy,
  input  wire  [1:0]                  cmd,
  input  wire  signed [23:0]          sample_value,
  input  wire  [31:0]                 sample_time,
  input  wire  [6:0]                  read_limit,
  output logic                        strobe,
  output logic [2:0]                  status,
  output logic                        entry_valid,
  output logic signed [23:0]          entry_value,
  output logic [31:0]                 entry_time,
  output logic [6:0]                  entry_count,
  output logic                        last
);
  import thds_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_WRITE, S_READ} state_t;

  state_t              state;
  logic [CntW-1:0]     fill;
  logic [CntW-1:0]     pos;      // places the ring has shifted in this pass
  logic [CntW-1:0]     nread;    // beats to emit in a read
  logic [CntW-1:0]     target;   // slot to write
  logic                dup;
  logic [31:0]         old_t;
  logic [CntW-1:0]     old_i;
  entry_t              smp;
  entry_t              head;
  ring_ctl_t           ctl;

  thds_ring u_ring (.clk(clk), .ctl(ctl), .head(head));

  logic [CntW-1:0] fill_top;
  assign fill_top = CntW'(Depth);

  // ring control: rotate during passes; load sample when the target slot
  // reaches the head
  always_comb begin
    ctl.shift = (state != S_IDLE);
    ctl.data  = (state == S_WRITE && pos == target) ? smp : head;
    ctl.load  = 1'b1;
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      fill   <= '0;
      strobe <= 1'b0;
      pos    <= '0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            smp.value    <= sample_value;
            smp.tstamp   <= sample_time;
            pos          <= '0;
            dup          <= 1'b0;
            old_t        <= '1;
            old_i        <= '0;
            status       <= ST_READ;
            entry_valid  <= 1'b0;
            entry_value  <= '0;
            entry_time   <= '0;
            last         <= 1'b1;
            unique case (cmd)
              CMD_CLEAR: begin
                fill        <= '0;
                strobe      <= 1'b1;
                status      <= ST_CLEARED;
                entry_count <= '0;
              end
              CMD_ADD: begin
                if (sample_value[23] || sample_value == '0 || sample_time == '0) begin
                  strobe      <= 1'b1;
                  status      <= ST_INVALID;
                  entry_count <= 7'(fill);
                end else begin
                  state <= S_SCAN;
                end
              end
              CMD_READ: begin
                if (fill == '0 || read_limit == '0) begin
                  strobe      <= 1'b1;
                  entry_count <= 7'(fill);
                end else begin
                  nread <= (read_limit < fill) ? read_limit : fill;
                  state <= S_READ;
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (pos < fill) begin
            if (head.tstamp == smp.tstamp) dup <= 1'b1;
            if (pos == '0 || head.tstamp < old_t) begin
              old_t <= head.tstamp;
              old_i <= pos;
            end
          end
          pos <= (pos == fill_top - 1'b1) ? '0 : pos + 1'b1;
          if (pos == fill_top - 1'b1) begin
            entry_count <= 7'(fill);
            if (dup || (pos < fill && head.tstamp == smp.tstamp)) begin
              strobe <= 1'b1; status <= ST_DUP; state <= S_IDLE;
            end else if (fill != fill_top) begin
              target <= fill; state <= S_WRITE; status <= ST_APPENDED;
            end else begin
              // full: last cell compared too
              if (head.tstamp < old_t) begin
                if (smp.tstamp > head.tstamp) begin
                  target <= pos; state <= S_WRITE; status <= ST_REPLACED;
                end else begin
                  strobe <= 1'b1; status <= ST_TOO_OLD; state <= S_IDLE;
                end
              end else if (smp.tstamp > old_t) begin
                target <= old_i; state <= S_WRITE; status <= ST_REPLACED;
              end else begin
                strobe <= 1'b1; status <= ST_TOO_OLD; state <= S_IDLE;
              end
            end
          end
        end
        S_WRITE: begin
          pos <= (pos == fill_top - 1'b1) ? '0 : pos + 1'b1;
          if (pos == fill_top - 1'b1) begin
            state  <= S_IDLE;
            strobe <= 1'b1;
            if (status == ST_APPENDED) begin
              fill        <= fill + 1'b1;
              entry_count <= 7'(fill + 1'b1);
            end else begin
              entry_count <= 7'(fill);
            end
          end
        end
        S_READ: begin
          if (pos < nread) begin
            strobe      <= 1'b1;
            status      <= ST_READ;
            entry_valid <= 1'b1;
            entry_value <= head.value;
            entry_time  <= head.tstamp;
            entry_count <= 7'(fill);
            last        <= (pos + 1'b1 == nread);
          end
          pos <= (pos == fill_top - 1'b1) ? '0 : pos + 1'b1;
          if (pos == fill_top - 1'b1) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: verif/tb_timestamped_history_dedup_store.sv
// ----------------------------------------------------------------------------
// tb_timestamped_history_dedup_store
// self-checking bench: directed and random commands against a behavioral copy of the store
// ----------------------------------------------------------------------------
// An initial block queues directed then random commands. A clocked driver
// presents them with random gaps, and its own predictor updates a copy of
// the store for every accepted beat and queues the expected result beats.
// A clocked monitor checks every strobe beat against the oldest expectation.
module tb_timestamped_history_dedup_store;
  import thds_pkg::*;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [23:0] value;
    logic [31:0]        tstamp;
    logic [6:0]         limit;
  } cmd_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        valid;
    logic [23:0] value;
    logic [31:0] tstamp;
    logic [6:0]  count;
    logic        last;
  } result_beat_t;

  logic               clk = 0;
  logic               rst = 1;
  logic               start = 0;
  logic               busy;
  logic [1:0]         cmd = CMD_CLEAR;
  logic signed [23:0] sample_value = '0;
  logic [31:0]        sample_time = '0;
  logic [6:0]         read_limit = '0;
  logic               strobe;
  logic [2:0]         status;
  logic               entry_valid;
  logic signed [23:0] entry_value;
  logic [31:0]        entry_time;
  logic [6:0]         entry_count;
  logic               last;

  cmd_beat_t    pending_cmds[$];
  result_beat_t expected_results[$];
  int           fail_count = 0;
  int           checked_count = 0;
  int           beat_count = 0;
  bit           quiet_stretch = 0;

  // behavioral copy of the store
  logic [23:0] hist_values[Depth];
  logic [31:0] hist_times[Depth];
  int          hist_fill = 0;

  timestamped_history_dedup_store i_dut (
    .clk, .rst, .start, .busy, .cmd, .sample_value, .sample_time, .read_limit,
    .strobe, .status, .entry_valid, .entry_value, .entry_time, .entry_count,
    .last
  );

  always #1 clk = ~clk;

  function automatic result_beat_t make_result(logic [2:0] st, logic v,
                                               logic [23:0] val,
                                               logic [31:0] ts, logic l);
    result_beat_t r;
    r.status = st;
    r.valid = v;
    r.value = val;
    r.tstamp = ts;
    r.count = hist_fill[6:0];
    r.last = l;
    return r;
  endfunction

  function automatic logic [2:0] store_sample(logic [23:0] val, logic [31:0] ts);
    int oldest;
    oldest = 0;
    if (val == 0 || val[23] || ts == 0) return ST_INVALID;
    for (int i = 0; i < hist_fill; i++)
      if (hist_times[i] == ts) return ST_DUP;
    if (hist_fill < Depth) begin
      hist_values[hist_fill] = val;
      hist_times[hist_fill] = ts;
      hist_fill++;
      return ST_APPENDED;
    end
    for (int i = 1; i < Depth; i++)
      if (hist_times[i] < hist_times[oldest]) oldest = i;
    if (ts > hist_times[oldest]) begin
      hist_values[oldest] = val;
      hist_times[oldest] = ts;
      return ST_REPLACED;
    end
    return ST_TOO_OLD;
  endfunction

  // works out the result beats of one accepted command
  task automatic predict_results(cmd_beat_t c);
    int n;
    case (c.cmd)
      CMD_CLEAR: begin
        hist_fill = 0;
        expected_results.push_back(make_result(ST_CLEARED, 0, '0, '0, 1));
      end
      CMD_ADD: begin
        logic [2:0] st;
        st = store_sample(c.value, c.tstamp);
        expected_results.push_back(make_result(st, 0, '0, '0, 1));
      end
      CMD_READ: begin
        n = (hist_fill < c.limit) ? hist_fill : c.limit;
        if (n > Depth) n = Depth;
        if (n == 0) expected_results.push_back(make_result(ST_READ, 0, '0, '0, 1));
        for (int i = 0; i < n; i++)
          expected_results.push_back(make_result(ST_READ, 1, hist_values[i],
                                                 hist_times[i], i == n - 1));
      end
      default: ;  // unused code: no result
    endcase
  endtask

  function automatic cmd_beat_t mk(logic [1:0] c, logic [23:0] v,
                                   logic [31:0] t, logic [6:0] l);
    cmd_beat_t b;
    b.cmd = c;
    b.value = v;
    b.tstamp = t;
    b.limit = l;
    return b;
  endfunction

  // driver: a beat is accepted at an edge with start high and busy low
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        predict_results(mk(cmd, sample_value, sample_time, read_limit));
        beat_count++;
      end
      if (!(start && busy)) begin
        if (pending_cmds.size() > 0 &&
            (quiet_stretch || $urandom_range(99) >= 34)) begin
          cmd_beat_t b;
          b = pending_cmds.pop_front();
          start <= 1;
          cmd <= b.cmd;
          sample_value <= b.value;
          sample_time <= b.tstamp;
          read_limit <= b.limit;
        end else begin
          start <= 0;
        end
      end
    end
  end

  // monitor: every strobe beat must match the oldest expectation
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat status %0d", $time, status);
        fail_count++;
      end else begin
        result_beat_t e;
        result_beat_t a;
        e = expected_results.pop_front();
        a = make_result(status, entry_valid, entry_value, entry_time, last);
        a.count = entry_count;
        checked_count++;
        if (a !== e) begin
          $display("%0t: mismatch expected st=%0d v=%0d val=%h t=%h cnt=%0d last=%0d",
                   $time, e.status, e.valid, e.value, e.tstamp, e.count, e.last);
          $display("%0t:          actual   st=%0d v=%0d val=%h t=%h cnt=%0d last=%0d",
                   $time, a.status, a.valid, a.value, a.tstamp, a.count, a.last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    logic [31:0] base_time;
    int mode;
    // directed: extremes, every command, each special case
    pending_cmds.push_back(mk(CMD_READ, 0, 0, 64));          // empty read
    pending_cmds.push_back(mk(CMD_ADD, 24'h7FFFFF, 32'hFFFFFFFF, 0));
    pending_cmds.push_back(mk(CMD_ADD, 24'h000001, 32'h00000001, 7'h7F));
    pending_cmds.push_back(mk(CMD_ADD, 24'h000005, 32'h00000001, 0)); // duplicate
    pending_cmds.push_back(mk(CMD_ADD, 0, 5, 0));             // zero value
    pending_cmds.push_back(mk(CMD_ADD, 24'h800000, 6, 0));    // negative value
    pending_cmds.push_back(mk(CMD_ADD, 24'hFFFFFF, 7, 0));
    pending_cmds.push_back(mk(CMD_ADD, 5, 0, 0));             // zero timestamp
    pending_cmds.push_back(mk(CMD_RSVD, 24'h123456, 9, 3));   // ignored code
    pending_cmds.push_back(mk(CMD_READ, 0, 0, 0));            // zero limit
    pending_cmds.push_back(mk(CMD_READ, 0, 0, 7'h7F));        // limit above depth
    pending_cmds.push_back(mk(CMD_READ, 0, 0, 1));
    pending_cmds.push_back(mk(CMD_CLEAR, 24'hFFFFFF, 32'hFFFFFFFF, 7'h7F));
    // fill to full with the two lowest times in slots 0 and 1
    for (int i = 0; i < Depth; i++)
      pending_cmds.push_back(mk(CMD_ADD, 24'($urandom_range(1, 24'h7FFFFF)),
                                32'((i < 2) ? 100 + i : 1000 + i), 0));
    pending_cmds.push_back(mk(CMD_ADD, 7, 50, 0));            // too old
    pending_cmds.push_back(mk(CMD_ADD, 7, 100, 0));           // duplicate when full
    pending_cmds.push_back(mk(CMD_ADD, 9, 5000, 0));          // replaces slot 0
    pending_cmds.push_back(mk(CMD_ADD, 9, 101, 0));           // duplicate
    pending_cmds.push_back(mk(CMD_ADD, 9, 102, 0));           // replaces slot 1
    pending_cmds.push_back(mk(CMD_READ, 0, 0, 64));
    pending_cmds.push_back(mk(CMD_CLEAR, 0, 0, 0));
    // random: mostly valid adds with clustered times, some reads and noise
    base_time = $urandom_range(1, 1000);
    for (int i = 0; i < 60; i++) begin
      mode = $urandom_range(99);
      if (mode < 60)
        pending_cmds.push_back(mk(CMD_ADD, 24'($urandom_range(1, 24'h7FFFFF)),
                                  base_time + 32'($urandom_range(0, 120)),
                                  7'($urandom)));
      else if (mode < 78)
        pending_cmds.push_back(mk(CMD_READ, 24'($urandom), $urandom,
                                  7'(($urandom_range(3) == 0) ? $urandom_range(64, 127)
                                                              : $urandom_range(0, 8))));
      else if (mode < 82)
        pending_cmds.push_back(mk(CMD_CLEAR, 24'($urandom), $urandom, 7'($urandom)));
      else if (mode < 86)
        pending_cmds.push_back(mk(CMD_RSVD, 24'($urandom), $urandom, 7'($urandom)));
      else
        pending_cmds.push_back(mk(CMD_ADD, 24'($urandom), $urandom, 7'($urandom)));
      if ($urandom_range(15) == 0) base_time = base_time + $urandom_range(50, 200);
    end
    pending_cmds.push_back(mk(CMD_ADD, 24'h7FFFFF, 32'hFFFFFFFF, 0));
    pending_cmds.push_back(mk(CMD_READ, 0, 0, 64));

    repeat (12) @(posedge clk);
    rst <= 0;
    repeat (300) @(posedge clk);
    quiet_stretch = 1;    // a stretch with no idling at all
    repeat (3000) @(posedge clk);
    quiet_stretch = 0;
    wait (pending_cmds.size() == 0);
    @(posedge clk);
    while (start || busy || expected_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d command beats, %0d result beats checked",
             beat_count, checked_count);
    if (fail_count == 0 && expected_results.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // generous limit: ~150 commands, the longest of them two full ring turns, with gaps
  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end
endmodule
